FILE: hw/rtl/srp_pkg.sv
// shared types, codes and helpers of the s-record parser
`default_nettype none

package srp_pkg;

    // data digits per flash word
    localparam int WORD_DIGITS = 8;
    localparam int WCNT_W      = $clog2(WORD_DIGITS + 1);

    // result kinds on the output tuser
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_EOF   = 2'd3;

    // special characters
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_Z       = 8'h5A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] CSUM_GOOD = 8'hFF;

    // one result request
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word;
        logic [31:0] addr;
    } result_t;

    // uppercase hex decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = {1'b1, 4'(c - 8'h41 + 8'h0A)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/srec_record_parser_unit.sv
// motorola s-record parser: characters in, flash word writes and record status out
`default_nettype none

// Takes one ASCII character per cycle on the s_ side and parses S-records. Each
// character is decoded and applied to the record state in the cycle it is accepted,
// and its result (if any) goes into the output register, or into the skid stage behind
// it, which lets the input keep flowing while the output register waits. s_tready only
// drops when both the output register and the skid stage are full. Sustained rate is
// one character per clock while s_tready stays high. Results are 0 word write, 1 record
// ok, 2 checksum error, 3 end of file; address and word are zero except on writes.
// cfg_data sets load_enable; with it low every character is dropped.
module srec_record_parser_unit
    import srp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,     // load_enable
    // character input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // rx_char
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,      // write_address [31:0], write_word [63:32]
    output logic [1:0]       m_tuser       // result_kind
);

    // parse phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_CNT_HI = 3'd2;
    localparam logic [2:0] PH_CNT_LO = 3'd3;
    localparam logic [2:0] PH_ADDR   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_CSUM   = 3'd6;

    logic              load_enable_reg;

    logic [2:0]        phase_reg, phase_next;
    logic              noload_reg, noload_next;
    logic [3:0]        addr_digits_reg, addr_digits_next;
    logic [7:0]        byte_count_reg, byte_count_next;
    logic [8:0]        digit_cnt_reg, digit_cnt_next;
    logic [8:0]        data_total_reg, data_total_next;
    logic [31:0]       rec_addr_reg, rec_addr_next;
    logic [31:0]       acc_reg, acc_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic [7:0]        csum_reg, csum_next;
    logic [4:0]        pend_reg, pend_next;

    logic              accept;
    logic [4:0]        hv;
    logic [3:0]        h;
    logic              clear_rec;
    logic              start_rec;
    logic              res_valid;
    result_t           res;
    logic [7:0]        bc;
    logic [8:0]        twice;
    logic [8:0]        need;
    logic [8:0]        dcnt;
    logic [WCNT_W-1:0] wcnt;

    result_t           out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              pop;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            load_enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            load_enable_reg <= cfg_data;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign hv       = hex_decode(s_tdata);
    assign h        = hv[3:0];

    // per-character record update
    always_comb
    begin
        phase_next       = phase_reg;
        noload_next      = noload_reg;
        addr_digits_next = addr_digits_reg;
        byte_count_next  = byte_count_reg;
        digit_cnt_next   = digit_cnt_reg;
        data_total_next  = data_total_reg;
        rec_addr_next    = rec_addr_reg;
        acc_next         = acc_reg;
        wcnt_next        = wcnt_reg;
        csum_next        = csum_reg;
        pend_next        = pend_reg;
        clear_rec        = 1'b0;
        start_rec        = 1'b0;
        res_valid        = 1'b0;
        res              = '0;
        bc               = {byte_count_reg[7:4], h};
        twice            = {bc, 1'b0};
        need             = {5'd0, addr_digits_reg} + 9'd2;
        dcnt             = digit_cnt_reg + 9'd1;
        wcnt             = wcnt_reg + WCNT_W'(1);

        if (accept && load_enable_reg) begin
            if (s_tdata == CHAR_S) begin
                clear_rec = 1'b1;
                start_rec = 1'b1;
            end else if (s_tdata == CHAR_Z) begin
                clear_rec = 1'b1;
                res_valid = 1'b1;
                res.kind  = KIND_EOF;
            end else if (s_tdata == CHAR_NEWLINE) begin
                if (phase_reg != PH_IDLE) begin
                    clear_rec = 1'b1;
                    res_valid = 1'b1;
                    res.kind  = (csum_reg == CSUM_GOOD) ? KIND_OK : KIND_ERROR;
                end
            end else if (hv[4] && phase_reg != PH_IDLE) begin
                if (phase_reg == PH_TYPE) begin
                    // type digit sets address length and whether the record loads
                    if (h inside {4'd2, 4'd6, 4'd8}) begin
                        addr_digits_next = 4'd6;
                    end else if (h inside {4'd3, 4'd7}) begin
                        addr_digits_next = 4'd8;
                    end else begin
                        addr_digits_next = 4'd4;
                    end
                    noload_next = !(h inside {[4'd1:4'd3]});
                    phase_next  = PH_CNT_HI;
                end else begin
                    // byte pairs into the checksum
                    if (pend_reg[4]) begin
                        csum_next = csum_reg + {pend_reg[3:0], h};
                        pend_next = 5'd0;
                    end else begin
                        pend_next = {1'b1, h};
                    end

                    case (phase_reg)
                        PH_CNT_HI:
                        begin
                            byte_count_next = {h, 4'h0};
                            phase_next      = PH_CNT_LO;
                        end
                        PH_CNT_LO:
                        begin
                            byte_count_next = bc;
                            data_total_next = (twice > need) ? (twice - need) : 9'd0;
                            digit_cnt_next  = 9'd0;
                            rec_addr_next   = 32'd0;
                            phase_next      = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            rec_addr_next = {rec_addr_reg[27:0], h};
                            if (dcnt >= {5'd0, addr_digits_reg}) begin
                                digit_cnt_next = 9'd0;
                                phase_next     = (data_total_reg != 9'd0) ? PH_DATA : PH_CSUM;
                            end else begin
                                digit_cnt_next = dcnt;
                            end
                        end
                        PH_DATA:
                        begin
                            acc_next       = {acc_reg[27:0], h};
                            wcnt_next      = wcnt;
                            digit_cnt_next = dcnt;
                            if (wcnt >= WCNT_W'(WORD_DIGITS)) begin
                                if (!noload_reg) begin
                                    res_valid = 1'b1;
                                    res.kind  = KIND_WRITE;
                                    res.addr  = rec_addr_reg;
                                    res.word  = {acc_reg[27:0], h};
                                end
                                rec_addr_next = rec_addr_reg + 32'd4;
                                acc_next      = 32'd0;
                                wcnt_next     = '0;
                            end
                            if (dcnt >= data_total_reg) begin
                                acc_next   = 32'd0;
                                wcnt_next  = '0;
                                phase_next = PH_CSUM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        // record restart or end
        if (clear_rec) begin
            phase_next       = start_rec ? PH_TYPE : PH_IDLE;
            noload_next      = 1'b0;
            addr_digits_next = 4'd0;
            byte_count_next  = 8'd0;
            digit_cnt_next   = 9'd0;
            data_total_next  = 9'd0;
            rec_addr_next    = 32'd0;
            acc_next         = 32'd0;
            wcnt_next        = '0;
            csum_next        = 8'd0;
            pend_next        = 5'd0;
        end
    end

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_IDLE;
            noload_reg      <= 1'b0;
            addr_digits_reg <= 4'd0;
            byte_count_reg  <= 8'd0;
            digit_cnt_reg   <= 9'd0;
            data_total_reg  <= 9'd0;
            rec_addr_reg    <= 32'd0;
            acc_reg         <= 32'd0;
            wcnt_reg        <= '0;
            csum_reg        <= 8'd0;
            pend_reg        <= 5'd0;
        end else begin
            phase_reg       <= phase_next;
            noload_reg      <= noload_next;
            addr_digits_reg <= addr_digits_next;
            byte_count_reg  <= byte_count_next;
            digit_cnt_reg   <= digit_cnt_next;
            data_total_reg  <= data_total_next;
            rec_addr_reg    <= rec_addr_next;
            acc_reg         <= acc_next;
            wcnt_reg        <= wcnt_next;
            csum_reg        <= csum_next;
            pend_reg        <= pend_next;
        end
    end

    // output register with skid stage
    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (!out_valid_reg) begin
            out_valid_reg <= res_valid;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (!out_valid_reg) begin
            out_reg <= res;
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.word, out_reg.addr};
    assign m_tuser  = out_reg.kind;

endmodule

`default_nettype wire

FILE: hw/rtl/srp_checker.sv
// port-level checks of the s-record parser and their binding
`default_nettype none

module srp_checker
    import srp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        cfg_ready
);

    // a stalled result request stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result request dropped or changed while stalled");

    // only word writes carry address and data
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_WRITE |-> m_tdata == 64'd0)
        else $error("status result with nonzero address or word");

    // input only stalls when a result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a stall clears in the cycle after the output drains
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("input stall outlived output drain");

    // configuration is never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration request refused");

endmodule

bind srec_record_parser_unit srp_checker u_srp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench of the s-record parser unit with scripted and random character streams
module tb_top;
    import srp_pkg::*;

    // record parse phases of the predictor
    typedef enum logic [2:0]
    {
        REC_IDLE,
        REC_TYPE,
        REC_COUNT_HI,
        REC_COUNT_LO,
        REC_ADDRESS,
        REC_DATA,
        REC_CHECKSUM
    } rec_phase_e;

    // ways a generated record departs from a clean one
    typedef enum int
    {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_SHORT_COUNT,
        FLAW_EARLY_END,
        FLAW_EXTRA_DIGITS,
        FLAW_ODD_DIGIT,
        FLAW_EOF_MID,
        FLAW_RESTART
    } rec_flaw_e;

    // receiver back-pressure styles
    typedef enum int
    {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN
    } ready_mode_e;

    localparam logic [7:0] DIGIT_ZERO    = "0";
    localparam logic [7:0] DIGIT_NINE    = "9";
    localparam logic [7:0] DIGIT_TEN     = "A";
    localparam logic [7:0] DIGIT_FIFTEEN = "F";
    localparam int DRAIN_CYCLES  = 8;
    localparam int FIRST_BATCH   = 560;
    localparam int SECOND_BATCH  = 240;
    localparam int MAX_DATA      = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    // predictor state
    logic                load_en_m = 1'b0;
    rec_phase_e          rec_phase = REC_IDLE;
    logic                no_load = 1'b0;
    logic [3:0]          addr_digits = '0;
    logic [7:0]          byte_cnt = '0;
    logic [8:0]          digit_cnt = '0;
    logic [8:0]          data_total = '0;
    logic [31:0]         rec_addr = '0;
    logic [31:0]         word_acc = '0;
    logic [WCNT_W-1:0]   word_digits = '0;
    logic [7:0]          byte_sum = '0;
    logic                nib_valid = 1'b0;
    logic [3:0]          nib = '0;

    result_t    expected_results[$];
    result_t    want;
    logic [7:0] char_q[$];
    int         chars_pushed = 0;
    int         chars_taken = 0;
    int         useful_chars = 0;
    int         errors = 0;
    logic       in_fire = 1'b0;

    // sender and receiver pacing
    int          burst_left = 0;
    int          gap_left = 0;
    int          rdy_count = 0;
    ready_mode_e rdy_mode = RDY_ALWAYS;
    logic [15:0] rdy_pattern = 16'hFFFF;
    logic [3:0]  rdy_pos = '0;

    srec_record_parser_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= DIGIT_ZERO && c <= DIGIT_NINE) || (c >= DIGIT_TEN && c <= DIGIT_FIFTEEN);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        return (c <= DIGIT_NINE) ? 4'(c - DIGIT_ZERO) : 4'(c - DIGIT_TEN + 8'd10);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? DIGIT_ZERO + 8'(v) : DIGIT_TEN + 8'(v - 4'd10);
    endfunction

    // any character that the parser skips
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex_digit(c) || c == CHAR_S || c == CHAR_Z || c == CHAR_NEWLINE)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic clear_record();
        rec_phase   = REC_IDLE;
        no_load     = 1'b0;
        addr_digits = '0;
        byte_cnt    = '0;
        digit_cnt   = '0;
        data_total  = '0;
        rec_addr    = '0;
        word_acc    = '0;
        word_digits = '0;
        byte_sum    = '0;
        nib_valid   = 1'b0;
        nib         = '0;
    endtask

    // advance the record state by one character and queue its result, if any
    task automatic apply_char(input logic [7:0] c);
        logic [3:0] h;
        logic [8:0] need;
        logic [8:0] twice;
        result_t    r;
        r = '0;
        if (!load_en_m)
            return;
        if (c == CHAR_S)
        begin
            clear_record();
            rec_phase = REC_TYPE;
            return;
        end
        if (c == CHAR_Z)
        begin
            clear_record();
            r.kind = KIND_EOF;
            expected_results.push_back(r);
            return;
        end
        if (c == CHAR_NEWLINE)
        begin
            if (rec_phase == REC_IDLE)
                return;
            r.kind = (byte_sum == CSUM_GOOD) ? KIND_OK : KIND_ERROR;
            expected_results.push_back(r);
            clear_record();
            return;
        end
        if (!is_hex_digit(c) || rec_phase == REC_IDLE)
            return;
        h = digit_value(c);

        // type digit picks the address length and whether data loads
        if (rec_phase == REC_TYPE)
        begin
            case (h)
                4'h2, 4'h6, 4'h8: addr_digits = 4'd6;
                4'h3, 4'h7:       addr_digits = 4'd8;
                default:          addr_digits = 4'd4;
            endcase
            no_load   = !(h >= 4'h1 && h <= 4'h3);
            rec_phase = REC_COUNT_HI;
            return;
        end

        // digits after the type pair up into the byte sum
        if (nib_valid)
        begin
            byte_sum  = byte_sum + {nib, h};
            nib_valid = 1'b0;
            nib       = '0;
        end
        else
        begin
            nib       = h;
            nib_valid = 1'b1;
        end

        case (rec_phase)
            REC_COUNT_HI:
            begin
                byte_cnt  = {h, 4'h0};
                rec_phase = REC_COUNT_LO;
            end
            REC_COUNT_LO:
            begin
                byte_cnt[3:0] = h;
                need       = 9'(addr_digits) + 9'd2;
                twice      = {byte_cnt, 1'b0};
                data_total = (twice > need) ? twice - need : 9'd0;
                digit_cnt  = '0;
                rec_addr   = '0;
                rec_phase  = REC_ADDRESS;
            end
            REC_ADDRESS:
            begin
                rec_addr  = {rec_addr[27:0], h};
                digit_cnt = digit_cnt + 9'd1;
                if (digit_cnt >= 9'(addr_digits))
                begin
                    digit_cnt = '0;
                    rec_phase = (data_total != 0) ? REC_DATA : REC_CHECKSUM;
                end
            end
            REC_DATA:
            begin
                word_acc    = {word_acc[27:0], h};
                word_digits = word_digits + 1'b1;
                digit_cnt   = digit_cnt + 9'd1;
                if (word_digits >= WORD_DIGITS)
                begin
                    if (!no_load)
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = rec_addr;
                        r.word = word_acc;
                        expected_results.push_back(r);
                    end
                    rec_addr    = rec_addr + 32'd4;
                    word_acc    = '0;
                    word_digits = '0;
                end
                // leftover digits of a partial word are dropped
                if (digit_cnt >= data_total)
                begin
                    word_acc    = '0;
                    word_digits = '0;
                    rec_phase   = REC_CHECKSUM;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // result check, then config and character prediction
    always @(posedge clk)
    begin
        in_fire = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: kind %0d addr %h word %h",
                             $time, m_tuser, m_tdata[31:0], m_tdata[63:32]);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata[31:0] !== want.addr ||
                        m_tdata[63:32] !== want.word)
                    begin
                        $display({"%0t: mismatch: expected kind %0d addr %h word %h, ",
                                  "got kind %0d addr %h word %h"},
                                 $time, want.kind, want.addr, want.word,
                                 m_tuser, m_tdata[31:0], m_tdata[63:32]);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                load_en_m = cfg_data;
            in_fire = s_tvalid && s_tready;
            if (in_fire)
            begin
                chars_taken++;
                apply_char(s_tdata);
            end
        end
    end

    // character driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (char_q.size() != 0)
            begin
                s_tdata  <= char_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver: switches between free flow, random and patterned stalls
    always @(negedge clk)
    begin
        if (rdy_count == 0)
        begin
            rdy_count   = $urandom_range(50, 300);
            rdy_mode    = ready_mode_e'($urandom_range(0, 2));
            rdy_pattern = 16'($urandom()) | 16'h0001;
        end
        rdy_count--;
        case (rdy_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                m_tready <= rdy_pattern[rdy_pos];
                rdy_pos = rdy_pos + 1'b1;
            end
        endcase
    end

    task automatic push_char(input logic [7:0] c, input bit noisy);
        if (noisy && $urandom_range(0, 5) == 0)
        begin
            char_q.push_back(noise_char());
            chars_pushed++;
        end
        char_q.push_back(c);
        chars_pushed++;
        useful_chars++;
    endtask

    // build one record, optionally damaged, and queue its characters
    task automatic send_record(input logic [3:0] rtype, input int ndata, input logic [31:0] addr,
                               input rec_flaw_e flaw, input bit noisy);
        int         addr_bytes;
        int         k;
        int         digits;
        int         stop_at;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] rec_bytes[$];
        addr_bytes = (rtype == 4'h2 || rtype == 4'h6 || rtype == 4'h8) ? 3 :
                     (rtype == 4'h3 || rtype == 4'h7) ? 4 : 2;
        rec_bytes.push_back(8'(addr_bytes + ndata + 1));
        if (flaw == FLAW_SHORT_COUNT)
            rec_bytes[0] = 8'($urandom_range(0, addr_bytes));
        for (k = addr_bytes - 1; k >= 0; k--)
            rec_bytes.push_back(addr[8*k +: 8]);
        for (k = 0; k < ndata; k++)
            rec_bytes.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        foreach (rec_bytes[i])
            sum = sum + rec_bytes[i];
        rec_bytes.push_back(~sum);
        if (flaw == FLAW_BAD_SUM)
            rec_bytes[rec_bytes.size() - 1] = ~sum ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_EXTRA_DIGITS)
            rec_bytes.push_back(8'($urandom_range(0, 255)));
        digits  = 2 * rec_bytes.size();
        stop_at = (flaw == FLAW_EARLY_END) ? $urandom_range(0, digits - 1) : digits;

        push_char(CHAR_S, noisy);
        push_char(hex_char(rtype), noisy);
        for (k = 0; k < stop_at; k++)
        begin
            b = rec_bytes[k / 2];
            push_char(hex_char(k[0] ? b[3:0] : b[7:4]), noisy);
        end
        if (flaw == FLAW_ODD_DIGIT)
            push_char(hex_char(4'($urandom_range(0, 15))), noisy);
        // a restarted record just runs into the next 'S'
        if (flaw == FLAW_EOF_MID)
            push_char(CHAR_Z, noisy);
        else if (flaw != FLAW_RESTART)
            push_char(CHAR_NEWLINE, noisy);
    endtask

    task automatic send_random_record();
        logic [3:0]  rtype;
        logic [31:0] addr;
        int          pick;
        int          ndata;
        rec_flaw_e   flaw;
        // occasional stray character between records
        pick = $urandom_range(0, 19);
        if (pick == 0)
            push_char(noise_char(), 1'b0);
        else if (pick == 1)
            push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        else if (pick == 2)
            push_char(CHAR_NEWLINE, 1'b0);
        else if (pick == 3)
            push_char(CHAR_Z, 1'b0);

        pick  = $urandom_range(0, 99);
        rtype = (pick < 75) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
        pick  = $urandom_range(0, 99);
        ndata = (pick < 85) ? $urandom_range(0, 24) :
                (pick < 98) ? $urandom_range(25, 64) : MAX_DATA;
        addr  = $urandom();
        if ($urandom_range(0, 7) == 0)
            addr[31:6] = '1;
        pick = $urandom_range(0, 99);
        flaw = (pick < 70) ? FLAW_NONE : rec_flaw_e'($urandom_range(1, 7));
        send_record(rtype, ndata, addr, flaw, $urandom_range(0, 3) == 0);
    endtask

    // hold off until all characters are taken and every result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (chars_taken != chars_pushed || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_load_enable(input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // parsing is off after reset: a full record must leave no trace
        send_record(4'h1, 4, 32'h0000_1234, FLAW_NONE, 1'b1);
        push_char(CHAR_Z, 1'b0);
        wait_drained();
        write_load_enable(1'b1);

        // idle characters: stray digit, newline, extreme codes, then end of file
        push_char(hex_char(4'hA), 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CHAR_Z, 1'b0);
        // load records of each address length, wrap of the write address
        send_record(4'h1, 4, 32'h0000_0000, FLAW_NONE, 1'b0);
        send_record(4'h3, 8, 32'hFFFF_FFFC, FLAW_NONE, 1'b0);
        send_record(4'h2, 3, 32'h00FF_FFFF, FLAW_NONE, 1'b1);
        // records that never load
        send_record(4'h5, 4, 32'h0000_0010, FLAW_NONE, 1'b0);
        send_record(4'h4, 4, 32'h0000_0020, FLAW_NONE, 1'b0);
        send_record(4'hF, 4, 32'h0000_0030, FLAW_NONE, 1'b0);
        // damaged records
        send_record(4'h3, 0, 32'h1000_0000, FLAW_SHORT_COUNT, 1'b0);
        send_record(4'h1, 4, 32'h0000_4000, FLAW_BAD_SUM, 1'b0);
        send_record(4'h2, 6, 32'h0012_3456, FLAW_EARLY_END, 1'b0);
        send_record(4'h3, 4, 32'h8000_0000, FLAW_EOF_MID, 1'b0);
        send_record(4'h1, 4, 32'h0000_ABCD, FLAW_RESTART, 1'b0);
        send_record(4'h1, 2, 32'h0000_0100, FLAW_EXTRA_DIGITS, 1'b0);
        send_record(4'h7, 2, 32'h0000_0200, FLAW_ODD_DIGIT, 1'b0);

        useful_chars = 0;
        while (useful_chars < FIRST_BATCH / 2)
            send_random_record();
        // sender holds until every result is back
        wait_drained();
        while (useful_chars < FIRST_BATCH)
            send_random_record();
        wait_drained();

        // parsing off again: everything ignored, state held
        write_load_enable(1'b0);
        repeat (6) send_random_record();
        wait_drained();
        write_load_enable(1'b1);

        useful_chars = 0;
        while (useful_chars < SECOND_BATCH)
            send_random_record();
        push_char(CHAR_NEWLINE, 1'b0);
        wait_drained();

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
